### src/bqr_pkg.sv
// ----------------------------------------------------------------------------
// bqr_pkg
// Shared types and codes of the bounded queue with removal: operation and
// status codes, and the command and status groups between controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bqr_pkg;

  // width of the length limit register
  localparam int unsigned MaxEntriesW = 5;

  // operation codes of a request
  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2,
    OP_REMOVE  = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // slot read address select
  typedef enum logic [1:0] {
    RD_HEAD  = 2'd0,
    RD_CUR   = 2'd1,
    RD_NEXT  = 2'd2,
    RD_NEXT2 = 2'd3
  } rd_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    push;
    logic    pop;
    logic    step;
    logic    move;
    logic    shrink;
    logic    report;
    logic    show_head;
    status_e status;
    rd_sel_e rd_sel;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    op_e  op;
    logic empty;
    logic full;
    logic match;
    logic last;
  } dp_stat_t;

endpackage

`default_nettype wire

### src/bqr_datapath.sv
// ----------------------------------------------------------------------------
// bqr_datapath
// Slot ring memory, head pointer, entry count, length limit register, the
// latched request, the search and compaction pointers and the result
// registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bqr_datapath #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [bqr_pkg::MaxEntriesW-1:0]      cfg_wdata_i,
  input  wire logic [1:0]                           op_i,
  input  wire logic [HANDLE_BITS-1:0]               entry_handle_i,
  input  wire bqr_pkg::dp_cmd_t                     cmd_i,
  output bqr_pkg::dp_stat_t                         stat_o,
  output logic                                      done_o,
  output logic [1:0]                                status_o,
  output logic [HANDLE_BITS-1:0]                    handle_out_o,
  output logic [$clog2(DEPTH+1)-1:0]                entry_count_o
);
  import bqr_pkg::*;

  localparam int unsigned PW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > MaxEntriesW) ? CW : MaxEntriesW;
  localparam logic [PW:0]   DepthW = (PW + 1)'(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  // ring index wrap, input below twice the depth
  function automatic logic [PW-1:0] wrap_idx(input logic [PW:0] v);
    if (v >= DepthW) begin
      return PW'(v - DepthW);
    end
    return PW'(v);
  endfunction

  logic [HANDLE_BITS-1:0]  slots_q [DEPTH];
  logic [HANDLE_BITS-1:0]  rd_data_q;
  logic [PW-1:0]           head_q, head_d;
  logic [CW-1:0]           count_q, count_d;
  logic [MaxEntriesW-1:0]  max_q;
  op_e                     op_q;
  logic [HANDLE_BITS-1:0]  handle_q;
  logic [PW-1:0]           cur_q;
  logic [PW-1:0]           pos_q;
  logic                    done_q;
  status_e                 status_q;
  logic [HANDLE_BITS-1:0]  hout_q;
  logic [CW-1:0]           cnt_out_q;

  logic [PW-1:0]           next_cur, next2_cur, tail, head_inc, raddr, waddr;
  logic                    we;
  logic [HANDLE_BITS-1:0]  wdata;

  // ring addresses
  assign next_cur  = wrap_idx({1'b0, cur_q} + (PW + 1)'(1));
  assign next2_cur = wrap_idx({1'b0, cur_q} + (PW + 1)'(2));
  assign tail      = wrap_idx({1'b0, head_q} + (PW + 1)'(count_q));
  assign head_inc  = wrap_idx({1'b0, head_q} + (PW + 1)'(1));

  // status toward the controller
  always_comb begin
    stat_o.op    = op_q;
    stat_o.empty = (count_q == '0);
    stat_o.full  = (count_q == DepthC) ||
                   ((max_q != '0) && (CMPW'(count_q) >= CMPW'(max_q)));
    stat_o.match = (rd_data_q == handle_q);
    stat_o.last  = ((CW'(pos_q) + CW'(1)) == count_q);
  end

  // read address select
  always_comb begin
    case (cmd_i.rd_sel)
      RD_HEAD:  raddr = head_q;
      RD_CUR:   raddr = cur_q;
      RD_NEXT:  raddr = next_cur;
      RD_NEXT2: raddr = next2_cur;
      default:  raddr = head_q;
    endcase
  end

  // write port: append at tail or close the gap during removal
  always_comb begin
    we    = cmd_i.push || cmd_i.move;
    waddr = cmd_i.push ? tail : cur_q;
    wdata = cmd_i.push ? handle_q : rd_data_q;
  end

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      slots_q[waddr] <= wdata;
    end
    rd_data_q <= slots_q[raddr];
  end

  // next head and count
  always_comb begin
    head_d  = cmd_i.pop ? head_inc : head_q;
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop || cmd_i.shrink) begin
      count_d = count_q - CW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      max_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= cmd_i.report;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  // request latch and walk pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_e'(op_i);
      handle_q <= entry_handle_i;
      cur_q    <= head_q;
      pos_q    <= '0;
    end else if (cmd_i.step || cmd_i.move) begin
      cur_q <= next_cur;
      pos_q <= pos_q + PW'(1);
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.report) begin
      status_q  <= cmd_i.status;
      hout_q    <= cmd_i.show_head ? rd_data_q : '0;
      cnt_out_q <= count_d;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign handle_out_o  = hout_q;
  assign entry_count_o = cnt_out_q;

endmodule

`default_nettype wire

### src/bqr_ctrl.sv
// ----------------------------------------------------------------------------
// bqr_ctrl
// Controller of the bounded queue: takes a request, runs the single step of
// enqueue, dequeue and peek, or the search and compaction walk of remove.
// ----------------------------------------------------------------------------
`default_nettype none

module bqr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire bqr_pkg::dp_stat_t  stat_i,
  output bqr_pkg::dp_cmd_t        cmd_o
);
  import bqr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_SHIFT
  } state_e;

  state_e state_q, state_d;

  // command decode and next state
  always_comb begin
    state_d = state_q;
    cmd_o   = '{
      load: 1'b0, push: 1'b0, pop: 1'b0, step: 1'b0, move: 1'b0,
      shrink: 1'b0, report: 1'b0, show_head: 1'b0,
      status: ST_OK, rd_sel: RD_HEAD
    };
    case (state_q)
      S_IDLE: begin
        cmd_o.rd_sel = RD_HEAD;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.rd_sel = RD_CUR;
        state_d      = S_IDLE;
        case (stat_i.op)
          OP_ENQUEUE: begin
            cmd_o.report = 1'b1;
            if (stat_i.full) begin
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.push = 1'b1;
            end
          end
          OP_DEQUEUE: begin
            cmd_o.report = 1'b1;
            if (stat_i.empty) begin
              cmd_o.status = ST_EMPTY;
            end else begin
              cmd_o.pop       = 1'b1;
              cmd_o.show_head = 1'b1;
            end
          end
          OP_PEEK: begin
            cmd_o.report = 1'b1;
            if (stat_i.empty) begin
              cmd_o.status = ST_EMPTY;
            end else begin
              cmd_o.show_head = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (stat_i.empty) begin
              cmd_o.report = 1'b1;
              cmd_o.status = ST_EMPTY;
            end else begin
              state_d = S_SEARCH;
            end
          end
          default: begin
            cmd_o.report = 1'b1;
          end
        endcase
      end
      // compare one slot a cycle from the head
      S_SEARCH: begin
        cmd_o.rd_sel = RD_NEXT;
        if (stat_i.match) begin
          state_d = S_SHIFT;
        end else if (stat_i.last) begin
          cmd_o.report = 1'b1;
          cmd_o.status = ST_NOT_FOUND;
          state_d      = S_IDLE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      // pull later slots one place toward the head
      S_SHIFT: begin
        cmd_o.rd_sel = RD_NEXT2;
        if (stat_i.last) begin
          cmd_o.shrink = 1'b1;
          cmd_o.report = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.move = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

### src/bounded_queue_with_removal.sv
// ----------------------------------------------------------------------------
// bounded_queue_with_removal
// FIFO of entry handles in a ring of DEPTH slots with a length limit and
// remove-by-value.
// ----------------------------------------------------------------------------
// Usage:
//   A request (op_i, entry_handle_i) is taken at a clock edge with start high
//   and busy low. Ops: enqueue, dequeue, peek head, remove a given handle.
//   Each request gives one result (status_o, handle_out_o, entry_count_o),
//   shown for exactly one cycle with done_o high; the receiver cannot stall.
//   Enqueue, dequeue and peek: the result shows in the cycle after the
//   working cycle, and a new request is taken in the cycle the result shows.
//   Remove walks the ring through the single memory read port, one slot a
//   cycle: search up to the match or the last entry, then, when the handle
//   is found, compaction of the later slots.
//   The length limit is written through cfg_we_i / cfg_wdata_i while the
//   block is idle; 0, or a value above DEPTH, means DEPTH.
//   Reset empties the queue, clears the limit and the controller; slot
//   contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_queue_with_removal #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        op_i,
  input  wire logic [HANDLE_BITS-1:0]            entry_handle_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [bqr_pkg::MaxEntriesW-1:0]   cfg_wdata_i,
  output logic                                   done_o,
  output logic [1:0]                             status_o,
  output logic [HANDLE_BITS-1:0]                 handle_out_o,
  output logic [$clog2(DEPTH+1)-1:0]             entry_count_o
);
  import bqr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller
  bqr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // datapath
  bqr_datapath #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .op_i           (op_i),
    .entry_handle_i (entry_handle_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .done_o         (done_o),
    .status_o       (status_o),
    .handle_out_o   (handle_out_o),
    .entry_count_o  (entry_count_o)
  );

  // a taken request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request taken but block not busy");

  // results are never back to back
  a_done_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in consecutive cycles");

  // an empty report always carries a zero count
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_EMPTY) |-> (entry_count_o == '0))
    else $error("empty status with nonzero count");

  // only a successful result carries a handle
  a_handle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> (handle_out_o == '0))
    else $error("handle on a failed result");

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded queue with removal. Requests go in
// through the start/busy handshake. A shadow copy of the ring, head and
// count predicts every result. Each done strobe is checked field by field
// against the oldest prediction. The length limit is rewritten between
// phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import bqr_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned HANDLE_BITS = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 11;
  localparam int unsigned PHASE_ITEMS = 50;

  // predicted result of one request
  typedef struct {
    op_e                   op;
    status_e               status;
    logic [HANDLE_BITS-1:0] handle;
    logic [4:0]            count;
  } queue_result_t;

  // shadow of the queue contents and the list of results still to come
  class queue_shadow;
    logic [HANDLE_BITS-1:0] ring [DEPTH];
    logic [3:0]             head_idx;
    int unsigned            held;
    logic [4:0]             len_limit;
    queue_result_t          pending_results [$];
    int unsigned            mismatch_cnt;
    int unsigned            fail_cnt;

    function new();
      foreach (ring[k]) ring[k] = '0;
      head_idx     = '0;
      held         = 0;
      len_limit    = '0;
      mismatch_cnt = 0;
      fail_cnt     = 0;
    endfunction

    function logic [3:0] slot_at(int unsigned pos);
      return 4'((head_idx + pos) % DEPTH);
    endfunction

    function logic [HANDLE_BITS-1:0] held_handle(int unsigned pos);
      return ring[slot_at(pos)];
    endfunction

    function int unsigned pending_count();
      return pending_results.size();
    endfunction

    // apply one accepted request to the shadow and queue its result
    function void log_request(op_e op, logic [HANDLE_BITS-1:0] h);
      queue_result_t r;
      int unsigned   lim;
      int unsigned   i;
      int unsigned   j;
      r.op     = op;
      r.status = ST_OK;
      r.handle = '0;
      lim = (len_limit == 0 || len_limit > DEPTH) ? DEPTH : len_limit;
      case (op)
        OP_ENQUEUE: begin
          if (held >= lim) begin
            r.status = ST_FULL;
          end else begin
            ring[slot_at(held)] = h;
            held++;
          end
        end
        OP_DEQUEUE: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.handle = ring[head_idx];
            head_idx = head_idx + 4'd1;
            held--;
          end
        end
        OP_PEEK: begin
          if (held == 0) r.status = ST_EMPTY;
          else r.handle = ring[head_idx];
        end
        default: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // search from the head, then close the gap
            i = 0;
            while (i < held && ring[slot_at(i)] != h) i++;
            if (i == held) begin
              r.status = ST_NOT_FOUND;
            end else begin
              for (j = i; j + 1 < held; j++) ring[slot_at(j)] = ring[slot_at(j + 1)];
              held--;
            end
          end
        end
      endcase
      r.count = 5'(held);
      pending_results.push_back(r);
    endfunction

    // compare one strobed result with the oldest prediction
    function void check_result(logic [1:0] st, logic [HANDLE_BITS-1:0] h, logic [4:0] cnt);
      queue_result_t r;
      if (pending_results.size() == 0) begin
        fail_cnt++;
        if (mismatch_cnt < 10)
          $display("unexpected result: status %0d handle %h count %0d", st, h, cnt);
        mismatch_cnt++;
        return;
      end
      r = pending_results.pop_front();
      if (st !== r.status || h !== r.handle || cnt !== r.count) begin
        fail_cnt++;
        if (mismatch_cnt < 10)
          $display("%s: expected status %0d handle %h count %0d, got status %0d handle %h count %0d",
                   r.op.name(), r.status, r.handle, r.count, st, h, cnt);
        mismatch_cnt++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [1:0]             op_i;
  logic [HANDLE_BITS-1:0] entry_handle_i;
  logic                   cfg_we_i;
  logic [MaxEntriesW-1:0] cfg_wdata_i;
  logic                   done_o;
  logic [1:0]             status_o;
  logic [HANDLE_BITS-1:0] handle_out_o;
  logic [4:0]             entry_count_o;

  queue_shadow sb;
  int unsigned cycle_cnt = 0;

  bounded_queue_with_removal #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .entry_handle_i (entry_handle_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .handle_out_o   (handle_out_o),
    .entry_count_o  (entry_count_o)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(status_o, handle_out_o, entry_count_o);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("bounded_queue_with_removal: mismatch");
      $finish;
    end
  end

  // present one request and hold it until taken
  task automatic send_request(op_e op, logic [HANDLE_BITS-1:0] h);
    @(negedge clk_i);
    start          <= 1'b1;
    op_i           <= op;
    entry_handle_i <= h;
    do @(posedge clk_i); while (busy);
    sb.log_request(op, h);
  endtask

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // stop sending and wait until every predicted result has come
  task automatic wait_results_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
  endtask

  // length limit write, block idle
  task automatic write_limit(logic [MaxEntriesW-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.len_limit = v;
  endtask

  // handle drawn from a small pool for duplicates, or fully random
  function automatic logic [HANDLE_BITS-1:0] pick_handle();
    if ($urandom_range(0, 1) == 0) return HANDLE_BITS'($urandom_range(0, 7)) ^ 16'hA500;
    return HANDLE_BITS'($urandom());
  endfunction

  // stimulus
  initial begin
    int unsigned            ph;
    int unsigned            n;
    int unsigned            fill_bias;
    bit                     gaps_on;
    logic [MaxEntriesW-1:0] lim;
    op_e                    op;
    logic [HANDLE_BITS-1:0] h;

    rst_ni         = 1'b0;
    start          = 1'b0;
    op_i           = OP_ENQUEUE;
    entry_handle_i = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    sb = new();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty queue cases, duplicates, middle, tail and not-found removal
    send_request(OP_DEQUEUE, 16'h0000);
    send_request(OP_PEEK,    16'hFFFF);
    send_request(OP_REMOVE,  16'h0001);
    send_request(OP_ENQUEUE, 16'h0000);
    send_request(OP_ENQUEUE, 16'hFFFF);
    send_request(OP_ENQUEUE, 16'h1234);
    send_request(OP_ENQUEUE, 16'hFFFF);
    send_request(OP_ENQUEUE, 16'hA5A5);
    send_request(OP_PEEK,    16'h0000);
    send_request(OP_REMOVE,  16'hFFFF);
    send_request(OP_REMOVE,  16'hBEEF);
    send_request(OP_REMOVE,  16'hA5A5);
    send_request(OP_DEQUEUE, 16'hFFFF);

    // limit lowered under the count
    wait_results_drained();
    write_limit(5'd1);
    send_request(OP_ENQUEUE, 16'h5555);
    send_request(OP_DEQUEUE, 16'h0000);
    send_request(OP_DEQUEUE, 16'h0000);
    send_request(OP_ENQUEUE, 16'hAAAA);
    send_request(OP_ENQUEUE, 16'h5555);
    send_request(OP_REMOVE,  16'hAAAA);
    send_request(OP_REMOVE,  16'hAAAA);

    // random phases, each with its own limit
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: lim = 5'd0;
        1: lim = 5'd16;
        2: lim = 5'd31;
        3: lim = 5'd2;
        4: lim = 5'd17;
        5: lim = 5'd1;
        default: lim = MaxEntriesW'($urandom_range(0, 31));
      endcase
      wait_results_drained();
      write_limit(lim);
      fill_bias = $urandom_range(25, 80);
      gaps_on   = ($urandom_range(0, 2) != 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < fill_bias) op = OP_ENQUEUE;
        else op = op_e'($urandom_range(1, 3));
        h = pick_handle();
        if (op == OP_REMOVE && sb.held != 0 && $urandom_range(0, 9) < 7)
          h = sb.held_handle($urandom_range(0, sb.held - 1));
        send_request(op, h);
        if (gaps_on) idle_cycles($urandom_range(0, 17));
        if ($urandom_range(0, 39) == 0) wait_results_drained();
      end
    end

    wait_results_drained();
    repeat (20) @(posedge clk_i);
    if (sb.fail_cnt == 0 && sb.pending_count() == 0) begin
      $display("bounded_queue_with_removal: match");
    end else begin
      $display("bounded_queue_with_removal: mismatch");
    end
    $finish;
  end

endmodule

### files.f
src/bqr_pkg.sv
src/bqr_datapath.sv
src/bqr_ctrl.sv
src/bounded_queue_with_removal.sv
sim/tb.sv
